/* src/d8fdw_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the D8 flow direction window unit.
// No dependencies.
package d8fdw_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_FACT,
    ST_DIST,
    ST_LO,
    ST_HI,
    ST_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       load;
    logic       clear;
    logic       fact;
    logic       scale;
    logic       lo;
    logic       hi;
    logic       cmp;
    logic [2:0] nb;
    logic       finish;
  } dp_cmd_t;

  typedef struct packed {
    logic emit;
    logic outlet;
  } dp_status_t;

  localparam logic [16:0] DIST_ORTHO = 17'd65536;
  localparam logic [16:0] DIST_DIAG  = 17'd46341;
  localparam logic signed [15:0] GUIDE_MAX = 16'sd16384;
  localparam logic signed [15:0] GUIDE_MIN = -16'sd16384;
  localparam logic [0:0] REG_PAGE_SIZE = 1'b0;
  localparam logic [0:0] REG_GUIDANCE_WEIGHT = 1'b1;

  function automatic logic signed [1:0] nb_dx(input logic [2:0] k);
    case (k)
      3'd0, 3'd3, 3'd5: nb_dx = -2'sd1;
      3'd1, 3'd6:       nb_dx = 2'sd0;
      default:          nb_dx = 2'sd1;
    endcase
  endfunction

  function automatic logic signed [1:0] nb_dy(input logic [2:0] k);
    case (k)
      3'd0, 3'd1, 3'd2: nb_dy = -2'sd1;
      3'd3, 3'd4:       nb_dy = 2'sd0;
      default:          nb_dy = 2'sd1;
    endcase
  endfunction

endpackage

/* src/d8fdw_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module d8fdw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* src/d8fdw_ctrl.sv */
`timescale 1ns / 1ps
// Controller: sequences load, per-neighbour scoring and result hand-off.
// Depends on d8fdw_pkg.
module d8fdw_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  d8fdw_pkg::dp_status_t status,
  output d8fdw_pkg::dp_cmd_t    cmd
);
  import d8fdw_pkg::*;

  state_t     state, state_next;
  logic [2:0] nb, nb_next;
  logic       out_free;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      nb        <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      nb    <= nb_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    nb_next    = nb;
    cmd        = '0;
    cmd.nb     = nb;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        cmd.clear = 1'b1;
        nb_next   = 3'd0;
        if (!status.emit) begin
          state_next = ST_IDLE;
        end else if (status.outlet) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_FACT;
        end
      end
      ST_FACT: begin
        cmd.fact   = 1'b1;
        state_next = ST_DIST;
      end
      ST_DIST: begin
        cmd.scale  = 1'b1;
        state_next = ST_LO;
      end
      ST_LO: begin
        cmd.lo     = 1'b1;
        state_next = ST_HI;
      end
      ST_HI: begin
        cmd.hi     = 1'b1;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        cmd.cmp = 1'b1;
        if (nb == 3'd7) begin
          state_next = ST_DONE;
        end else begin
          nb_next    = nb + 3'd1;
          state_next = ST_FACT;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end
endmodule

/* src/d8fdw_datapath.sv */
`timescale 1ns / 1ps
// Datapath: config registers, line store, 3x3 window, scoring and result registers.
// Depends on d8fdw_pkg and d8fdw_ram.
module d8fdw_datapath #(
  parameter int MAX_PAGE  = 256,
  parameter int ELEV_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [0:0]                  cfg_index,
  input  logic [15:0]                 cfg_data,
  input  logic signed [ELEV_BITS-1:0] conditioned_elevation,
  input  logic signed [15:0]          guidance,
  input  logic                        cell_available,
  input  logic                        is_outlet,
  input  d8fdw_pkg::dp_cmd_t          cmd,
  output d8fdw_pkg::dp_status_t       status,
  output logic [7:0]                  cell_x,
  output logic [7:0]                  cell_y,
  output logic                        has_flow,
  output logic signed [1:0]           step_x,
  output logic signed [1:0]           step_y,
  output logic                        leaves_page
);
  import d8fdw_pkg::*;

  localparam int LINE_W = MAX_PAGE + 2;
  localparam int AW     = $clog2(LINE_W);
  localparam int PW     = (AW + 1 > 10) ? AW + 1 : 10;
  localparam int CELL_W = ELEV_BITS + 18;
  localparam int SW     = ELEV_BITS + 48;

  logic [8:0]  page_size;
  logic [15:0] guidance_weight;
  logic [AW-1:0] column_count, row_count;
  logic [CELL_W-1:0] cur;
  logic [CELL_W-1:0] win [9];
  logic [2*CELL_W-1:0] rdata;
  logic [PW-1:0] p_eff, x_ext, y_ext, cx, rx, ry;
  logic emit;

  logic [CELL_W-1:0] ctr, nbr;
  logic signed [ELEV_BITS:0] drop;
  logic signed [15:0] g_clamp;
  logic signed [31:0] wg;
  logic [ELEV_BITS-1:0] drop_r;
  logic ok_r;
  logic [30:0] factor_r;
  logic [47:0] m_r;
  logic [ELEV_BITS+23:0] plo, phi;
  logic [SW-1:0] score, best;
  logic found;
  logic [2:0] best_k;
  logic signed [1:0] bdx, bdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_size       <= 9'd256;
      guidance_weight <= 16'd0;
    end else if (cfg_write) begin
      if (cfg_index == REG_PAGE_SIZE) begin
        page_size <= cfg_data[8:0];
      end else begin
        guidance_weight <= cfg_data;
      end
    end
  end

  always_comb begin
    if (page_size == 9'd0) begin
      p_eff = PW'(1);
    end else if (PW'(page_size) > PW'(MAX_PAGE)) begin
      p_eff = PW'(MAX_PAGE);
    end else begin
      p_eff = PW'(page_size);
    end
  end

  assign x_ext = PW'(column_count);
  assign y_ext = PW'(row_count);
  assign emit  = (x_ext >= PW'(2)) && (x_ext <= p_eff + PW'(1)) &&
                 (y_ext >= PW'(2)) && (y_ext <= p_eff + PW'(1));
  assign status.emit   = emit;
  assign status.outlet = win[5][0];

  d8fdw_ram #(
    .WIDTH (2 * CELL_W),
    .DEPTH (LINE_W)
  ) u_line_store (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (column_count),
    .wdata ({rdata[CELL_W-1:0], cur}),
    .re    (cmd.accept),
    .raddr (column_count),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (cmd.load) begin
      if (x_ext >= p_eff + PW'(1)) begin
        column_count <= '0;
        if (y_ext >= p_eff + PW'(1)) begin
          row_count <= '0;
        end else begin
          row_count <= row_count + AW'(1);
        end
      end else begin
        column_count <= column_count + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur <= {conditioned_elevation, guidance, cell_available, is_outlet};
    end
    if (cmd.load) begin
      for (int r = 0; r < 3; r++) begin
        win[r*3]   <= win[r*3+1];
        win[r*3+1] <= win[r*3+2];
      end
      win[2] <= rdata[2*CELL_W-1:CELL_W];
      win[5] <= rdata[CELL_W-1:0];
      win[8] <= cur;
      cx     <= x_ext - PW'(1);
      ry     <= y_ext - PW'(1);
    end
  end

  assign ctr = win[4];
  assign nbr = win[4 + 3 * int'(nb_dy(cmd.nb)) + int'(nb_dx(cmd.nb))];

  always_comb begin
    drop = $signed({ctr[CELL_W-1], ctr[CELL_W-1:18]})
         - $signed({nbr[CELL_W-1], nbr[CELL_W-1:18]});
    if ($signed(nbr[17:2]) > GUIDE_MAX) begin
      g_clamp = GUIDE_MAX;
    end else if ($signed(nbr[17:2]) < GUIDE_MIN) begin
      g_clamp = GUIDE_MIN;
    end else begin
      g_clamp = $signed(nbr[17:2]);
    end
    wg    = $signed({16'd0, guidance_weight}) * 32'(g_clamp);
    score = {phi, 24'd0} + SW'(plo);
  end

  always_ff @(posedge clk) begin
    if (cmd.fact) begin
      drop_r   <= drop[ELEV_BITS-1:0];
      ok_r     <= nbr[1] && (drop > 0);
      factor_r <= 31'(32'sd1073741824 + wg);
    end
    if (cmd.scale) begin
      m_r <= 48'(factor_r) *
             48'((nb_dx(cmd.nb) != 2'sd0 && nb_dy(cmd.nb) != 2'sd0) ? DIST_DIAG : DIST_ORTHO);
    end
    if (cmd.lo) begin
      plo <= (ELEV_BITS+24)'(drop_r) * (ELEV_BITS+24)'(m_r[23:0]);
    end
    if (cmd.hi) begin
      phi <= (ELEV_BITS+24)'(drop_r) * (ELEV_BITS+24)'(m_r[47:24]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      found  <= 1'b0;
      best_k <= 3'd0;
    end else if (cmd.cmp && ok_r && (!found || score > best)) begin
      found  <= 1'b1;
      best   <= score;
      best_k <= cmd.nb;
    end
  end

  always_comb begin
    bdx = nb_dx(best_k);
    bdy = nb_dy(best_k);
    rx  = cx + PW'(bdx);
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      cell_x      <= 8'(cx - PW'(1));
      cell_y      <= 8'(ry - PW'(1));
      has_flow    <= found;
      step_x      <= found ? bdx : 2'sd0;
      step_y      <= found ? bdy : 2'sd0;
      leaves_page <= found && ((rx == '0) || (ry + PW'(bdy) == '0) ||
                               (rx > p_eff) || (ry + PW'(bdy) > p_eff));
    end
  end
endmodule

/* src/d8_flow_direction_window_unit.sv */
`timescale 1ns / 1ps
// Top level of the D8 flow direction window unit.
// Depends on d8fdw_pkg, d8fdw_ctrl and d8fdw_datapath.
//
//  channel  | handshake           | payload
//  ---------+---------------------+--------------------------------------------------
//  input    | in_valid / in_stall | conditioned_elevation, guidance, cell_available,
//           |                     | is_outlet
//  output   | out_valid/out_stall | cell_x, cell_y, has_flow, step_x, step_y,
//           |                     | leaves_page
//  config   | cfg_write           | cfg_index, cfg_data
//
// Halo and outlet cells go through accept, then line store write and window shift;
// outlet cells then add the result step. Other interior cells score each of eight
// neighbours in turn on one shared multiply path (factor, distance, two partial
// products, compare). Reset is synchronous; the line store is not cleared.
// A stalled result holds in the output register; the next transaction is accepted
// meanwhile and waits only at its own result.
module d8_flow_direction_window_unit #(
  parameter int MAX_PAGE  = 256,
  parameter int ELEV_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [0:0]                  cfg_index,
  input  logic [15:0]                 cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [ELEV_BITS-1:0] conditioned_elevation,
  input  logic signed [15:0]          guidance,
  input  logic                        cell_available,
  input  logic                        is_outlet,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  cell_x,
  output logic [7:0]                  cell_y,
  output logic                        has_flow,
  output logic signed [1:0]           step_x,
  output logic signed [1:0]           step_y,
  output logic                        leaves_page
);
  import d8fdw_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  d8fdw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  d8fdw_datapath #(
    .MAX_PAGE  (MAX_PAGE),
    .ELEV_BITS (ELEV_BITS)
  ) u_datapath (
    .clk                   (clk),
    .rst                   (rst),
    .cfg_write             (cfg_write),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .conditioned_elevation (conditioned_elevation),
    .guidance              (guidance),
    .cell_available        (cell_available),
    .is_outlet             (is_outlet),
    .cmd                   (cmd),
    .status                (status),
    .cell_x                (cell_x),
    .cell_y                (cell_y),
    .has_flow              (has_flow),
    .step_x                (step_x),
    .step_y                (step_y),
    .leaves_page           (leaves_page)
  );
endmodule
